FILE: hw/rtl/xdfd_pkg.sv
// ----------------------------------------------------------------------------
// xdfd_pkg
// Shared types and constants of the XOR delta frame decoder.
// ----------------------------------------------------------------------------
package xdfd_pkg;

  localparam int STORE_DEPTH = 8192;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int FRAME_W = 14;
  localparam int COUNT_W = 7;

  localparam logic [FRAME_W-1:0] FRAME_BYTES_RESET = 14'd1024;
  localparam logic [FRAME_W-1:0] OFFSET_MAX        = 14'h3FFF;
  localparam logic [7:0]         CTRL_SKIP         = 8'h80;
  localparam logic [7:0]         CTRL_COUNT        = 8'h7F;

  localparam logic [1:0] KIND_DELTA = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [12:0] address;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       frame_done;
    logic       frame_truncated;
  } out_item_t;

  // Decision of the stream parser for the byte being completed.
  typedef struct packed {
    logic lit_write;
    logic done;
    logic truncated;
  } parse_t;

endpackage

FILE: hw/rtl/xdfd_ram.sv
// ----------------------------------------------------------------------------
// xdfd_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module xdfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/xdfd_parser.sv
// ----------------------------------------------------------------------------
// xdfd_parser
// Run-length delta stream parser: keeps the running offset and run state.
// ----------------------------------------------------------------------------
module xdfd_parser import xdfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  input  logic [FRAME_W-1:0] frame_bytes,
  output logic [FRAME_W-1:0] offset,
  output parse_t             ctl
);

  logic [COUNT_W-1:0] literals_left;
  logic               discarding;
  logic               truncated_flag;

  logic [FRAME_W-1:0] offset_next;
  logic [COUNT_W-1:0] literals_left_next;
  logic               discarding_next;
  logic               truncated_flag_next;

  logic [FRAME_W:0]   adv_sum;
  logic [FRAME_W:0]   run_end;
  logic [COUNT_W-1:0] adv_n;

  always_comb begin
    offset_next         = offset;
    literals_left_next  = literals_left;
    discarding_next     = discarding;
    truncated_flag_next = truncated_flag;
    ctl                 = '0;

    adv_n   = (literals_left != '0) ? COUNT_W'(1) : data_byte[COUNT_W-1:0];
    adv_sum = {1'b0, offset} + {{(FRAME_W+1-COUNT_W){1'b0}}, adv_n};
    run_end = {1'b0, offset} + {{(FRAME_W+1-8){1'b0}}, data_byte};

    priority if (discarding) begin
    end else if (literals_left != '0) begin
      ctl.lit_write      = (32'(offset) < STORE_DEPTH);
      offset_next        = adv_sum[FRAME_W] ? OFFSET_MAX : adv_sum[FRAME_W-1:0];
      literals_left_next = literals_left - COUNT_W'(1);
    end else if ((data_byte & CTRL_SKIP) != '0) begin
      offset_next = adv_sum[FRAME_W] ? OFFSET_MAX : adv_sum[FRAME_W-1:0];
    end else if (run_end > {1'b0, frame_bytes}) begin
      discarding_next     = 1'b1;
      truncated_flag_next = 1'b1;
    end else begin
      literals_left_next = data_byte[COUNT_W-1:0];
    end

    if (last_byte) begin
      ctl.done            = 1'b1;
      ctl.truncated       = truncated_flag_next;
      offset_next         = '0;
      literals_left_next  = '0;
      discarding_next     = 1'b0;
      truncated_flag_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset         <= '0;
      literals_left  <= '0;
      discarding     <= 1'b0;
      truncated_flag <= 1'b0;
    end else if (step) begin
      offset         <= offset_next;
      literals_left  <= literals_left_next;
      discarding     <= discarding_next;
      truncated_flag <= truncated_flag_next;
    end
  end

endmodule

FILE: hw/rtl/xor_delta_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// xor_delta_frame_decoder_top
// Applies a run-length XOR delta to a byte frame store and serves reads.
// ----------------------------------------------------------------------------
//  channel | direction | signals                      | payload
//  in      | input     | in_valid, in_ready, in_data  | in_item_t
//  out     | output    | out_valid, out_ready, out_data | out_item_t
//  cfg     | input     | cfg_valid, cfg_ready, cfg_data | frame bytes, 14 bits
//
// A delta or read transaction reads the frame store when it is accepted,
// then modifies, writes back and loads the result register once out is free.
// A clear transaction sweeps the store one byte per cycle.
// Reset starts the same sweep, with in_ready low.
// A new transaction is taken while the previous result still waits on out.
// ----------------------------------------------------------------------------
module xor_delta_frame_decoder_top import xdfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [FRAME_W-1:0] cfg_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_CLEAR = 2'd2;

  logic [1:0]         state;
  logic [1:0]         state_next;
  in_item_t           item;
  logic               rd_in_range;
  logic               clr_resp;
  logic [ADDR_W-1:0]  clr_cnt;
  logic [FRAME_W-1:0] frame_bytes;

  logic               accept;
  logic               out_free;
  logic               step;
  logic               finish;
  logic [FRAME_W-1:0] offset;
  parse_t             ctl;
  out_item_t          result;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [7:0]         mem_wdata;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [7:0]         mem_rdata;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign finish    = (state == ST_EXEC) && out_free;
  assign step      = finish && (item.kind == KIND_DELTA);

  assign mem_re    = accept && ((in_data.kind == KIND_DELTA) || (in_data.kind == KIND_READ));
  assign mem_raddr = (in_data.kind == KIND_READ) ? ADDR_W'(in_data.address) : ADDR_W'(offset);

  // The sweep owns the write port; otherwise a literal writes back its XOR.
  assign mem_we    = (state == ST_CLEAR) || (step && ctl.lit_write);
  assign mem_waddr = (state == ST_CLEAR) ? clr_cnt : ADDR_W'(offset);
  assign mem_wdata = (state == ST_CLEAR) ? 8'h00 : (mem_rdata ^ item.data_byte);

  xdfd_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  xdfd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .data_byte   (item.data_byte),
    .last_byte   (item.last_byte),
    .frame_bytes (frame_bytes),
    .offset      (offset),
    .ctl         (ctl)
  );

  always_comb begin
    result = '0;
    if ((item.kind == KIND_READ) && rd_in_range) begin
      result.read_data = mem_rdata;
    end
    if (item.kind == KIND_DELTA) begin
      result.frame_done      = ctl.done;
      result.frame_truncated = ctl.truncated;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (in_data.kind == KIND_CLEAR) ? ST_CLEAR : ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (clr_cnt == ADDR_W'(STORE_DEPTH - 1)) begin
          state_next = clr_resp ? ST_EXEC : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_cnt     <= '0;
      clr_resp    <= 1'b0;
      out_valid   <= 1'b0;
      frame_bytes <= FRAME_BYTES_RESET;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        frame_bytes <= cfg_data;
      end
      if (accept) begin
        clr_resp <= (in_data.kind == KIND_CLEAR);
        clr_cnt  <= '0;
      end else if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item        <= in_data;
      rd_in_range <= (32'(in_data.address) < STORE_DEPTH);
    end
    if (finish) begin
      out_data <= result;
    end
  end

endmodule

FILE: hw/rtl/xdfd_checker.sv
// ----------------------------------------------------------------------------
// xdfd_checker
// Port-level assertions for the XOR delta frame decoder.
// ----------------------------------------------------------------------------
module xdfd_checker import xdfd_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A waiting result must hold until its transaction completes.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_trunc_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_truncated |-> out_data.frame_done)
    else $error("truncation flagged without frame end");

  a_done_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_done |-> out_data.read_data == 8'h00)
    else $error("frame end result carries read data");

  // The store is being cleared right after reset, so no input is taken.
  a_reset_sweep: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input taken while store clears after reset");

endmodule

bind xor_delta_frame_decoder_top xdfd_checker u_xdfd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
